### design/sclw_pkg.sv
// package for the serial character display writer
// shared types, register indexes, reset values and the slow command check
// no dependencies
`default_nettype none

package sclw_pkg;

   typedef enum logic [1:0] {
      REQ_COMMAND = 2'd0,
      REQ_CHAR    = 2'd1,
      REQ_CURSOR  = 2'd2
   } req_kind_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } seq_state_type;

   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_BIT_HOLD     = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE_PULSE = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHAR_GAP     = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CMD_SETTLE   = 8'd3;

   localparam logic [7:0]  BIT_HOLD_RESET     = 8'd10;
   localparam logic [7:0]  ENABLE_PULSE_RESET = 8'd2;
   localparam logic [7:0]  CHAR_GAP_RESET     = 8'd10;
   localparam logic [15:0] CMD_SETTLE_RESET   = 16'd50000;

   localparam logic [7:0] ROW1_BASE = 8'h80;
   localparam logic [7:0] ROW2_BASE = 8'hC0;
   localparam logic [7:0] ROW3_BASE = 8'h94;
   localparam logic [7:0] ROW4_BASE = 8'hD4;

   // steps within one nibble
   localparam logic [3:0] STEP_RS_FIRST = 4'd8;
   localparam logic [3:0] STEP_ENABLE   = 4'd12;
   localparam logic [3:0] STEP_CLOSE    = 4'd13;

   typedef struct packed {
      logic       rs;
      logic       slow;
      logic [7:0] code;
   } cmd_type;

   typedef struct packed {
      logic [7:0]  bit_hold;
      logic [7:0]  enable_pulse;
      logic [7:0]  char_gap;
      logic [15:0] cmd_settle;
   } timing_type;

   typedef struct packed {
      logic        data;
      logic        clk;
      logic        en;
      logic [15:0] hold;
      logic        last;
   } pin_type;

   function automatic logic is_slow_cmd(input logic [7:0] c);
      return c inside {8'h0C, 8'h01, 8'h0E, 8'h0F, 8'h10,
                       8'h1E, 8'h18, 8'h08, 8'h14, 8'h02};
   endfunction

endpackage

`default_nettype wire

### design/sclw_if.sv
// request and response channel interfaces
// valid/ready handshake with payload; no dependencies
`default_nettype none

interface sclw_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] byte_value;
   logic [7:0] column;
   logic [2:0] row;

   modport source (output valid, req_type, byte_value, column, row, input ready);
   modport sink (input valid, req_type, byte_value, column, row, output ready);
endinterface

interface sclw_rsp_if;
   logic        valid;
   logic        ready;
   logic        data_pin;
   logic        shift_clock;
   logic        latch_pin;
   logic        enable_pin;
   logic [15:0] hold_us;
   logic        last;

   modport source (output valid, data_pin, shift_clock, latch_pin, enable_pin, hold_us,
                   last, input ready);
   modport sink (input valid, data_pin, shift_clock, latch_pin, enable_pin, hold_us,
                 last, output ready);
endinterface

`default_nettype wire

### design/sclw_code_unit.sv
// request decode: turns a request into the byte to send, rs and slow flag
// depends on sclw_pkg
`default_nettype none

module sclw_code_unit
   import sclw_pkg::*;
(
   input  wire logic [1:0] req_type,
   input  wire logic [7:0] byte_value,
   input  wire logic [7:0] column,
   input  wire logic [2:0] row,
   output logic            go,
   output cmd_type         cmd
);

   logic [7:0] base;
   logic       row_ok;
   logic [7:0] code;

   always_comb begin
      base   = ROW1_BASE;
      row_ok = 1'b1;
      case (row)
         3'd1: begin
            base = ROW1_BASE;
         end
         3'd2: begin
            base = ROW2_BASE;
         end
         3'd3: begin
            base = ROW3_BASE;
         end
         3'd4: begin
            base = ROW4_BASE;
         end
         default: begin
            row_ok = 1'b0;
         end
      endcase
   end

   always_comb begin
      go   = 1'b0;
      code = byte_value;
      case (req_type)
         REQ_COMMAND: begin
            go = 1'b1;
         end
         REQ_CHAR: begin
            go = 1'b1;
         end
         REQ_CURSOR: begin
            go   = row_ok;
            code = base + column - 8'd1;
         end
         default: begin
            go = 1'b0;
         end
      endcase
      cmd.code = code;
      cmd.rs   = (req_type == REQ_CHAR);
      cmd.slow = (req_type != REQ_CHAR) && is_slow_cmd(code);
   end

endmodule

`default_nettype wire

### design/sclw_seq.sv
// pin state sequencer: step counter and byte shift register, one pin state per step
// depends on sclw_pkg
`default_nettype none

module sclw_seq
   import sclw_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire cmd_type    cmd,
   input  wire timing_type timing,
   input  wire logic       advance,
   output logic            busy,
   output pin_type         pin
);

   seq_state_type state_ff, state_in;
   logic [3:0]    sub_ff, sub_in;
   logic          nib_ff, nib_in;
   logic [7:0]    shift_ff, shift_in;
   logic          rs_ff, rs_in;
   logic          slow_ff, slow_in;
   logic          final_step;

   assign final_step = nib_ff && (sub_ff == STEP_CLOSE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (advance && final_step) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy = (state_ff == ST_RUN);
      pin.data = rs_ff;
      pin.clk  = 1'b0;
      pin.en   = 1'b0;
      pin.hold = {8'd0, timing.bit_hold};
      pin.last = 1'b0;
      if (sub_ff < STEP_RS_FIRST) begin
         pin.data = shift_ff[7];
         pin.clk  = sub_ff[0];
      end else if (sub_ff < STEP_ENABLE) begin
         pin.clk  = sub_ff[0];
      end else if (sub_ff == STEP_ENABLE) begin
         pin.en   = 1'b1;
         pin.hold = {8'd0, timing.enable_pulse};
      end else if (!nib_ff) begin
         pin.hold = rs_ff ? {8'd0, timing.char_gap} : 16'd0;
      end else begin
         pin.hold = slow_ff ? timing.cmd_settle : 16'd0;
         pin.last = 1'b1;
      end
   end

   always_comb begin
      sub_in   = sub_ff;
      nib_in   = nib_ff;
      shift_in = shift_ff;
      rs_in    = rs_ff;
      slow_in  = slow_ff;
      if (state_ff == ST_IDLE) begin
         if (start) begin
            sub_in   = 4'd0;
            nib_in   = 1'b0;
            shift_in = cmd.code;
            rs_in    = cmd.rs;
            slow_in  = cmd.slow;
         end
      end else if (advance) begin
         if (sub_ff == STEP_CLOSE) begin
            sub_in = 4'd0;
            nib_in = 1'b1;
         end else begin
            sub_in = sub_ff + 4'd1;
         end
         // shift after the clock high level of each data bit
         if ((sub_ff < STEP_RS_FIRST) && sub_ff[0]) begin
            shift_in = {shift_ff[6:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      sub_ff   <= sub_in;
      nib_ff   <= nib_in;
      shift_ff <= shift_in;
      rs_ff    <= rs_in;
      slow_ff  <= slow_in;
   end

endmodule

`default_nettype wire

### design/serial_char_lcd_writer_top.sv
// top level of the serial character display writer
// depends on sclw_pkg, sclw_if, sclw_code_unit and sclw_seq
//
//   channel  direction  carries
//   req      in         request type, byte, column, row
//   rsp      out        pin levels, hold time, last flag
//   csr      in         timing register writes
//
// a request is taken while the sequencer is idle, then gives 28 pin states, one per cycle while rsp
// is ready; the 14-step nibble sequencer sets this count
// requests that give no pin states (bad row, unknown type) are taken and dropped
// req is not ready while the sequencer runs; a stalled rsp holds the sequencer
// synchronous reset returns the sequencer to idle and the timing registers to defaults
`default_nettype none

module serial_char_lcd_writer_top
   import sclw_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   sclw_req_if.sink                    req,
   sclw_rsp_if.source                  rsp,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   timing_type timing_ff, timing_in;
   logic       rsp_valid_ff, rsp_valid_in;
   pin_type    pin_ff, pin_in;
   logic       go;
   cmd_type    cmd;
   logic       busy;
   logic       advance;
   logic       start;
   pin_type    pin;

   sclw_code_unit u_code (
      .req_type   (req.req_type),
      .byte_value (req.byte_value),
      .column     (req.column),
      .row        (req.row),
      .go         (go),
      .cmd        (cmd)
   );

   sclw_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .cmd     (cmd),
      .timing  (timing_ff),
      .advance (advance),
      .busy    (busy),
      .pin     (pin)
   );

   assign req.ready = !busy;
   assign start     = req.valid && !busy && go;
   assign advance   = busy && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      pin_in       = pin_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         pin_in       = pin;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      timing_in = timing_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_BIT_HOLD: begin
               timing_in.bit_hold = csr_wdata[7:0];
            end
            CSR_ENABLE_PULSE: begin
               timing_in.enable_pulse = csr_wdata[7:0];
            end
            CSR_CHAR_GAP: begin
               timing_in.char_gap = csr_wdata[7:0];
            end
            CSR_CMD_SETTLE: begin
               timing_in.cmd_settle = csr_wdata;
            end
            default: begin
               timing_in = timing_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff           <= 1'b0;
         timing_ff.bit_hold     <= BIT_HOLD_RESET;
         timing_ff.enable_pulse <= ENABLE_PULSE_RESET;
         timing_ff.char_gap     <= CHAR_GAP_RESET;
         timing_ff.cmd_settle   <= CMD_SETTLE_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         timing_ff    <= timing_in;
      end
   end

   always_ff @(posedge clock) begin
      pin_ff <= pin_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.data_pin    = pin_ff.data;
   assign rsp.shift_clock = pin_ff.clk;
   assign rsp.latch_pin   = pin_ff.clk;
   assign rsp.enable_pin  = pin_ff.en;
   assign rsp.hold_us     = pin_ff.hold;
   assign rsp.last        = pin_ff.last;

endmodule

`default_nettype wire
